FILE: hw/rtl/serial_adc_read_averager_top_macros.svh
// Assertion macros for the serial converter read averager checker.
// Used by sra_checker.sv; expects clk and rst_n in the scope of use.
`ifndef SERIAL_ADC_READ_AVERAGER_TOP_MACROS_SVH
`define SERIAL_ADC_READ_AVERAGER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sra_pkg.sv
// Package for the serial converter read averager: payload types, phase codes,
// controller state type and the pin decode function. No dependencies.
`default_nettype none

package sra_pkg;

  localparam int DATA_BITS = 8;

  // Phase codes of one sample sequence
  localparam logic [4:0] PHASE_CS   = 5'd0;
  localparam logic [4:0] PHASE_DATA = 5'd8;
  localparam logic [4:0] PHASE_LAST = 5'(8 + 2 * DATA_BITS - 1);
  localparam logic [4:0] PHASE_IDLE = 5'd31;

  // Restoring divider: one quotient bit per step over the 16-bit sum
  localparam int DIV_STEPS = 16;
  localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

  typedef struct packed {
    logic       command;
    logic       channel;
    logic [7:0] sample_count;
    logic       dout_level;
  } sra_in_t;

  typedef struct packed {
    logic       chip_select;
    logic       serial_clock;
    logic       data_to_adc;
    logic       busy_res;
    logic       done_res;
    logic [7:0] average;
  } sra_out_t;

  typedef struct packed {
    logic cs;
    logic sclk;
    logic din;
  } sra_pins_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
  } sra_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_needed;
    logic div_done;
  } sra_status_t;

  typedef enum logic {
    CT_READY,
    CT_DIVIDE
  } sra_ctl_state_t;

  function automatic logic phase_busy(input logic [4:0] phase);
    return phase <= PHASE_LAST;
  endfunction

  // Pin levels driven while in a given phase
  function automatic sra_pins_t phase_pins(input logic [4:0] phase, input logic chan);
    sra_pins_t p;
    logic      odd;
    odd = ~chan;
    p   = '0;
    if (phase_busy(phase)) begin
      if (phase == PHASE_CS) begin
        p.cs = 1'b1;
      end else if (phase <= 5'd4) begin
        p.din  = 1'b1;
        p.sclk = (phase == 5'd2) || (phase == 5'd4);
      end else if (phase < PHASE_DATA) begin
        p.din  = odd;
        p.sclk = (phase == 5'd6);
      end else begin
        p.din  = odd;
        p.sclk = ~phase[0];
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sra_ctrl.sv
// Controller for the serial converter read averager: handshake and divide
// sequencing. Depends on sra_pkg.
`default_nettype none

module sra_ctrl
  import sra_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  wire         out_ready,
  output sra_cmd_t    cmd,
  input  sra_status_t status
);

  sra_ctl_state_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CT_READY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      CT_READY: begin
        in_ready   = ~out_valid_r | out_ready;
        cmd.accept = in_valid & in_ready;
        if (cmd.accept) begin
          if (status.div_needed) begin
            state_nxt = CT_DIVIDE;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      CT_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt     = CT_READY;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = CT_READY;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sra_datapath.sv
// Datapath for the serial converter read averager: bus sequencer registers,
// accumulator, restoring divider and result register. Depends on sra_pkg.
`default_nettype none

module sra_datapath
  import sra_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  sra_in_t      in_data,
  input  wire          cfg_we,
  input  wire  [15:0]  cfg_wdata,
  input  sra_cmd_t     cmd,
  output sra_status_t  status,
  output sra_out_t     out_data
);

  logic [15:0] half_period_r;
  logic [4:0]  phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  total_r, total_nxt;
  logic        chan_r, chan_nxt;
  logic [7:0]  last_avg_r, last_avg_nxt;
  logic        done;
  logic        div_needed;
  logic [15:0] hp;
  logic [16:0] tick_inc;
  sra_pins_t   pins;
  sra_out_t    out_r;

  logic [15:0] dvd_r;
  logic [7:0]  rem_r;
  logic [3:0]  div_cnt_r;
  logic [8:0]  rem_sh;
  logic        q_bit;
  logic [15:0] quot;
  logic [7:0]  div_avg;

  assign hp       = (half_period_r == 16'd0) ? 16'd1 : half_period_r;
  assign tick_inc = {1'b0, tick_r} + 17'd1;

  // One transaction: start command or one bus tick
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    shift_nxt    = shift_r;
    sum_nxt      = sum_r;
    left_nxt     = left_r;
    total_nxt    = total_r;
    chan_nxt     = chan_r;
    last_avg_nxt = last_avg_r;
    done         = 1'b0;
    div_needed   = 1'b0;
    if (in_data.command) begin
      if (!phase_busy(phase_r)) begin
        if (in_data.sample_count == 8'd0) begin
          last_avg_nxt = 8'd0;
          done         = 1'b1;
          phase_nxt    = PHASE_IDLE;
        end else begin
          chan_nxt  = in_data.channel;
          left_nxt  = in_data.sample_count;
          total_nxt = in_data.sample_count;
          sum_nxt   = 16'd0;
          shift_nxt = 8'd0;
          tick_nxt  = 16'd0;
          phase_nxt = PHASE_CS;
        end
      end
    end else if (phase_busy(phase_r)) begin
      if (tick_inc >= {1'b0, hp}) begin
        tick_nxt = 16'd0;
        // sample the data line at the end of each data low phase
        if (phase_r >= PHASE_DATA && phase_r[0]) begin
          shift_nxt = {shift_r[6:0], in_data.dout_level};
        end
        if (phase_r == PHASE_LAST) begin
          sum_nxt  = sum_r + {8'd0, shift_nxt};
          left_nxt = left_r - 8'd1;
          if (left_nxt == 8'd0) begin
            done       = 1'b1;
            div_needed = 1'b1;
            phase_nxt  = PHASE_IDLE;
          end else begin
            shift_nxt = 8'd0;
            phase_nxt = PHASE_CS;
          end
        end else begin
          phase_nxt = phase_r + 5'd1;
        end
      end else begin
        tick_nxt = tick_inc[15:0];
      end
    end
  end

  // Tick items show the pins of the tick, start items those after it
  assign pins = in_data.command ? phase_pins(phase_nxt, chan_nxt) : phase_pins(phase_r, chan_r);

  // Divider step
  assign rem_sh  = {rem_r, dvd_r[15]};
  assign q_bit   = rem_sh >= {1'b0, total_r};
  assign quot    = {dvd_r[14:0], q_bit};
  assign div_avg = (total_r == 8'd0) ? 8'd0 : quot[7:0];

  // Configuration and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= 16'd1;
      phase_r       <= PHASE_IDLE;
      tick_r        <= 16'd0;
      shift_r       <= 8'd0;
      sum_r         <= 16'd0;
      left_r        <= 8'd0;
      total_r       <= 8'd0;
      chan_r        <= 1'b0;
      last_avg_r    <= 8'd0;
    end else begin
      if (cfg_we) begin
        half_period_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        phase_r    <= phase_nxt;
        tick_r     <= tick_nxt;
        shift_r    <= shift_nxt;
        sum_r      <= sum_nxt;
        left_r     <= left_nxt;
        total_r    <= total_nxt;
        chan_r     <= chan_nxt;
        last_avg_r <= last_avg_nxt;
      end else if (cmd.div_step && div_cnt_r == DIV_LAST) begin
        last_avg_r <= div_avg;
      end
    end
  end

  // Divider registers and result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_r.chip_select  <= pins.cs;
      out_r.serial_clock <= pins.sclk;
      out_r.data_to_adc  <= pins.din;
      out_r.busy_res     <= phase_busy(phase_nxt);
      out_r.done_res     <= done;
      out_r.average      <= last_avg_nxt;
      dvd_r              <= sum_nxt;
      rem_r              <= 8'd0;
      div_cnt_r          <= 4'd0;
    end else if (cmd.div_step) begin
      dvd_r     <= quot;
      rem_r     <= q_bit ? 8'(rem_sh - {1'b0, total_r}) : rem_sh[7:0];
      div_cnt_r <= div_cnt_r + 4'd1;
      if (div_cnt_r == DIV_LAST) begin
        out_r.average <= div_avg;
      end
    end
  end

  assign status.div_needed = div_needed;
  assign status.div_done   = (div_cnt_r == DIV_LAST);
  assign out_data          = out_r;

endmodule

`default_nettype wire

FILE: hw/rtl/serial_adc_read_averager_top.sv
// Top level of the serial converter read averager: controller plus datapath.
// Depends on sra_pkg, sra_ctrl and sra_datapath.
//
// Each input transaction is either one bus tick or a start command and yields
// exactly one result transaction. Ticks and starts are taken one per clock
// cycle while the result side keeps up; after the tick that finishes a run,
// the average is formed by a 16-step restoring divider (one quotient bit per
// cycle) before the result is posted and the next input is taken. A single
// output register holds the result; input is taken while it is empty or
// being drained in the same cycle.
`default_nettype none

module serial_adc_read_averager_top
  import sra_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_ready,
  input  sra_in_t      in_data,
  output logic         out_valid,
  input  wire          out_ready,
  output sra_out_t     out_data,
  input  wire          cfg_we,
  input  wire  [15:0]  cfg_wdata
);

  sra_cmd_t    cmd;
  sra_status_t status;

  // Handshake and divide sequencing
  sra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Bus sequencer, accumulator and divider
  sra_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/sra_checker.sv
// Port-level checker for the serial converter read averager, bound to the top.
// Depends on sra_pkg and serial_adc_read_averager_top_macros.svh.
`default_nettype none

`include "serial_adc_read_averager_top_macros.svh"

module sra_checker
  import sra_pkg::*;
(
  input wire      clk,
  input wire      rst_n,
  input wire      out_valid,
  input wire      out_ready,
  input sra_out_t out_data
);

  // A stalled result holds
  `SRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_data), "result changed while stalled")

  // A finished run is no longer busy
  `SRA_ASSERT_IMPL(a_done_idle, out_valid && out_data.done_res,
                   !out_data.busy_res, "done with busy set")

  // Idle without completion drives all pins low
  `SRA_ASSERT_IMPL(a_idle_pins, out_valid && !out_data.busy_res && !out_data.done_res,
                   !out_data.chip_select && !out_data.serial_clock && !out_data.data_to_adc,
                   "pins active while idle")

  // Chip select high only in the select phase of a run
  `SRA_ASSERT_IMPL(a_cs_phase, out_valid && out_data.chip_select,
                   out_data.busy_res && !out_data.serial_clock && !out_data.data_to_adc,
                   "chip select with clock or data")

endmodule

bind serial_adc_read_averager_top sra_checker u_sra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: dv/tb_serial_adc_read_averager_top.sv
// Testbench for serial_adc_read_averager_top: directed table, then random tick/start traffic
// checked against a local model of the serial read-and-average sequence.
// Depends on sra_pkg and the RTL of the block; stands alone otherwise.
`default_nettype none

module tb_serial_adc_read_averager_top;
  import sra_pkg::*;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Typed results: {cs, sclk, din, busy, done} then average
  localparam sra_out_t RES_IDLE      = '0;
  localparam sra_out_t RES_ZERO_DONE = {5'b00001, 8'd0};
  localparam sra_out_t RES_FIRST_CS  = {5'b10010, 8'd0};

  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    sra_in_t  item;
    int       reps;
    bit       typed;
    sra_out_t want;
  } script_row_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  sra_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sra_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Local copy of the reader state and its one register
  logic [15:0] half_period = 16'd1;
  logic [4:0]  seq_phase   = PHASE_IDLE;
  logic [15:0] tick_cnt    = '0;
  logic [7:0]  rx_shift    = '0;
  logic [15:0] rx_sum      = '0;
  logic [7:0]  reads_left  = '0;
  logic [7:0]  reads_total = '0;
  logic        chan_sel    = 1'b0;
  logic [7:0]  avg_hold    = '0;

  sra_out_t pending_reads_q[$];

  int err_count    = 0;
  int checked      = 0;
  int items_sent   = 0;
  int runs_done    = 0;
  int sink_hold    = 0;
  bit calm_snk     = 1'b0;
  bit calm_src     = 1'b0;

  serial_adc_read_averager_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 45);
  endfunction

  // Pin levels {cs, sclk, din} for the current phase
  function automatic logic [2:0] bus_pins();
    logic       odd;
    logic [4:0] rel;
    logic [2:0] p;
    odd = ~chan_sel;
    rel = seq_phase - PHASE_DATA;
    p   = 3'b000;
    if (seq_phase <= PHASE_LAST) begin
      if (seq_phase == PHASE_CS)
        p = 3'b100;
      else if (seq_phase <= 5'd4)              // start and single-ended bits
        p = {1'b0, (seq_phase == 5'd2) || (seq_phase == 5'd4), 1'b1};
      else if (seq_phase < PHASE_DATA)         // odd bit, then the wait
        p = {1'b0, seq_phase == 5'd6, odd};
      else                                     // data clocks: high then low
        p = {1'b0, ~rel[0], odd};
    end
    return p;
  endfunction

  // Advance the reader by one input transaction, return the result it gives
  function automatic sra_out_t advance_reader(input sra_in_t it);
    logic [2:0]  pins;
    logic [15:0] hp;
    logic [16:0] nxt;
    logic [15:0] quo;
    logic [4:0]  rel;
    logic        done;
    done = 1'b0;
    hp   = (half_period == 16'd0) ? 16'd1 : half_period;
    if (it.command == CMD_START) begin
      if (seq_phase > PHASE_LAST) begin
        if (it.sample_count == 8'd0) begin
          avg_hold  = 8'd0;
          done      = 1'b1;
          seq_phase = PHASE_IDLE;
        end else begin
          chan_sel    = it.channel;
          reads_left  = it.sample_count;
          reads_total = it.sample_count;
          rx_sum      = '0;
          rx_shift    = '0;
          tick_cnt    = '0;
          seq_phase   = PHASE_CS;
        end
      end
      pins = bus_pins();
    end else begin
      pins = bus_pins();
      if (seq_phase <= PHASE_LAST) begin
        nxt = {1'b0, tick_cnt} + 17'd1;
        if (nxt >= {1'b0, hp}) begin
          tick_cnt = '0;
          rel = seq_phase - PHASE_DATA;
          // sample the data line at the end of each low phase
          if (seq_phase >= PHASE_DATA && rel[0])
            rx_shift = {rx_shift[6:0], it.dout_level};
          if (seq_phase == PHASE_LAST) begin
            rx_sum     = rx_sum + {8'd0, rx_shift};
            reads_left = reads_left - 8'd1;
            if (reads_left == 8'd0) begin
              quo       = rx_sum / {8'd0, reads_total};
              avg_hold  = quo[7:0];
              done      = 1'b1;
              seq_phase = PHASE_IDLE;
              runs_done++;
            end else begin
              rx_shift  = '0;
              seq_phase = PHASE_CS;
            end
          end else begin
            seq_phase = seq_phase + 5'd1;
          end
        end else begin
          tick_cnt = nxt[15:0];
        end
      end
    end
    return {pins, seq_phase <= PHASE_LAST, done, avg_hold};
  endfunction

  task automatic flag_result(input string why, input sra_out_t want, input sra_out_t got);
    if (err_count < 10)
      $display("[%0t] %s: want cs=%b sclk=%b din=%b busy=%b done=%b avg=%0d",
               $time, why, want.chip_select, want.serial_clock, want.data_to_adc,
               want.busy_res, want.done_res, want.average,
               "  | got cs=%b sclk=%b din=%b busy=%b done=%b avg=%0d",
               got.chip_select, got.serial_clock, got.data_to_adc,
               got.busy_res, got.done_res, got.average);
    err_count++;
  endtask

  // Send one transaction, then log its expected result once accepted
  task automatic put_item(input sra_in_t it, input bit typed, input sra_out_t want);
    int       gap;
    sra_out_t pred;
    gap = (calm_src || $urandom_range(0, 9) < 6) ? 0 : gap_len();
    if ($urandom_range(0, 59) == 0) calm_src = ~calm_src;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pred = advance_reader(it);
    pending_reads_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Let all results drain and the divider finish before touching the register
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reads_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_period(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    half_period = v;
    cfg_we    <= 1'b0;
  endtask

  // Random traffic: mostly full runs with random data, some ignored starts and idle ticks.
  // Any run still open when the budget is spent is ticked to completion.
  task automatic run_random(input int budget, input bit no_runs);
    logic [31:0] raw;
    sra_in_t it;
    int      used;
    int      r;
    used = 0;
    while (used < budget || seq_phase <= PHASE_LAST) begin
      raw = $urandom;
      it  = raw[$bits(sra_in_t)-1:0];
      if (seq_phase <= PHASE_LAST) begin
        if (used >= budget || $urandom_range(0, 24) != 0) begin
          it.command = CMD_TICK;
          used++;
        end else begin
          it.command = CMD_START;               // ignored while busy
        end
      end else begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          it.command = CMD_TICK;                // idle tick, no effect
        end else begin
          it.command = CMD_START;
          used++;
          if (no_runs || r == 2)
            it.sample_count = 8'd0;
          else if (half_period <= 16'd1 && $urandom_range(0, 11) == 0)
            it.sample_count = 8'($urandom_range(5, 8));
          else
            it.sample_count = 8'($urandom_range(1, (half_period <= 16'd1) ? 3 : 1));
        end
      end
      put_item(it, 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure with calm stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm_snk <= ~calm_snk;
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (!calm_snk && $urandom_range(0, 9) < 3) begin
      out_ready <= 1'b0;
      sink_hold <= gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result transaction with the oldest expectation
  always @(posedge clk) begin
    sra_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reads_q.size() == 0) begin
        flag_result("result with nothing pending", 'x, out_data);
      end else begin
        want = pending_reads_q.pop_front();
        checked++;
        if (out_data.chip_select  !== want.chip_select  ||
            out_data.serial_clock !== want.serial_clock ||
            out_data.data_to_adc  !== want.data_to_adc  ||
            out_data.busy_res     !== want.busy_res     ||
            out_data.done_res     !== want.done_res     ||
            out_data.average      !== want.average)
          flag_result("result mismatch", want, out_data);
      end
    end
  end

  // Stimulus
  initial begin
    script_row_t script [11];
    logic [15:0] hp_plan     [5];
    int          budget_plan [5];

    // idle ticks, zero count, a start, a start while busy, then full runs at the extremes
    script[0]  = '{'{CMD_TICK,  1'b1, 8'hFF, 1'b1},    2, 1'b1, RES_IDLE};
    script[1]  = '{'{CMD_START, 1'b1, 8'd0,  1'b1},    1, 1'b1, RES_ZERO_DONE};
    script[2]  = '{'{CMD_START, 1'b0, 8'd1,  1'b0},    1, 1'b1, RES_FIRST_CS};
    script[3]  = '{'{CMD_START, 1'b1, 8'hFF, 1'b1},    1, 1'b1, RES_FIRST_CS};
    script[4]  = '{'{CMD_TICK,  1'b0, 8'd0,  1'b1},   24, 1'b0, RES_IDLE};
    script[5]  = '{'{CMD_START, 1'b1, 8'd2,  1'b0},    1, 1'b0, RES_IDLE};
    script[6]  = '{'{CMD_TICK,  1'b1, 8'd0,  1'b0},   48, 1'b0, RES_IDLE};
    script[7]  = '{'{CMD_START, 1'b1, 8'd3,  1'b1},    1, 1'b0, RES_IDLE};
    script[8]  = '{'{CMD_TICK,  1'b0, 8'd0,  1'b1},   72, 1'b0, RES_IDLE};
    script[9]  = '{'{CMD_START, 1'b0, 8'd0,  1'b0},    1, 1'b1, RES_ZERO_DONE};
    script[10] = '{'{CMD_TICK,  1'b0, 8'd0,  1'b0},    1, 1'b1, RES_IDLE};

    // half period per phase: zero acts as one; all ones only with zero-count starts
    hp_plan     = '{16'd0, 16'd2, 16'd3, 16'd1, 16'hFFFF};
    budget_plan = '{40, 30, 20, 40, 20};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      repeat (script[i].reps) put_item(script[i].item, script[i].typed, script[i].want);

    foreach (hp_plan[k]) begin
      settle();
      write_half_period(hp_plan[k]);
      run_random(budget_plan[k], hp_plan[k] == 16'hFFFF);
    end
    settle();

    $display("Sent %0d input transactions, checked %0d results, %0d averaging runs completed",
             items_sent, checked, runs_done);
    $display("Half periods covered: reset value, 0, 1, 2, 3 and 65535");
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sra_pkg.sv
hw/rtl/sra_ctrl.sv
hw/rtl/sra_datapath.sv
hw/rtl/serial_adc_read_averager_top.sv
hw/rtl/sra_checker.sv
dv/tb_serial_adc_read_averager_top.sv
